// ===== rtl/log_record_parser_crc_check_top_defines.svh =====
// Assertion macros for the log record parser.
// Each macro expects clk_i, and LRP_ASSERT also rst_ni, in the scope where it is used.
`ifndef LOG_RECORD_PARSER_CRC_CHECK_TOP_DEFINES_SVH
`define LOG_RECORD_PARSER_CRC_CHECK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside of reset.
`define LRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define LRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LRP_ASSERT(lbl, prop, msg)
`define LRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/lrp_crc_pkg.sv =====
`timescale 1ns / 1ps

package lrp_crc_pkg;

  // Record parsing phases, one-hot.
  typedef enum logic [6:0] {
    PH_SEQ  = 7'b0000001,
    PH_OP   = 7'b0000010,
    PH_KLEN = 7'b0000100,
    PH_KEY  = 7'b0001000,
    PH_VLEN = 7'b0010000,
    PH_VAL  = 7'b0100000,
    PH_CRC  = 7'b1000000
  } phase_e;

  // Result kinds.
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Record status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
  localparam logic [2:0] ST_SHORT_KEY  = 3'd2;
  localparam logic [2:0] ST_SHORT_REC  = 3'd3;
  localparam logic [2:0] ST_CRC_ERROR  = 3'd4;

  // Field sizes and CRC constants.
  localparam logic [4:0]  FIXED_BYTES = 5'd21;
  localparam logic [31:0] SEQ_BYTES   = 32'd8;
  localparam logic [31:0] LEN_BYTES   = 32'd4;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  // Default depth of the result queue.
  localparam int unsigned LRP_FIFO_DEPTH = 4;

  localparam int unsigned TDATA_W = 152;

  // One result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [63:0] seq_num;
    logic [7:0]  op_code;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // Results produced by the parser for one accepted byte.
  typedef struct packed {
    logic    data_vld;
    logic    stat_vld;
    result_t data_res;
    result_t stat_res;
  } parse_res_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] r;
    r = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/lrp_crc_parser.sv =====
`timescale 1ns / 1ps
`include "log_record_parser_crc_check_top_defines.svh"

module lrp_crc_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_vld_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   in_eob_i,
  output lrp_crc_pkg::parse_res_t res_o
);
  import lrp_crc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic [4:0]  bytes_seen_q, bytes_seen_d;
  logic [63:0] seq_q, seq_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] stored_q, stored_d;

  logic [31:0] crc_upd;
  logic [31:0] fcnt_inc;
  logic        done;
  logic        emit_data;
  logic [1:0]  data_kind;
  logic [2:0]  st;

  // Field decode and state update for one byte.
  always_comb begin
    phase_d      = phase_q;
    fcnt_d       = fcnt_q;
    seq_d        = seq_q;
    op_d         = op_q;
    klen_d       = klen_q;
    vlen_d       = vlen_q;
    crc_d        = crc_q;
    stored_d     = stored_q;
    done         = 1'b0;
    emit_data    = 1'b0;
    data_kind    = KIND_KEY;
    crc_upd      = crc_byte(crc_q, in_byte_i);
    fcnt_inc     = fcnt_q + 32'd1;
    bytes_seen_d = (bytes_seen_q < FIXED_BYTES) ? bytes_seen_q + 5'd1 : bytes_seen_q;

    case (phase_q)
      PH_OP: begin
        crc_d   = crc_upd;
        op_d    = in_byte_i;
        phase_d = PH_KLEN;
        fcnt_d  = 32'd0;
      end
      PH_KLEN: begin
        crc_d  = crc_upd;
        klen_d = {klen_q[23:0], in_byte_i};
        fcnt_d = fcnt_inc;
        if (fcnt_inc >= LEN_BYTES) begin
          fcnt_d  = 32'd0;
          phase_d = (klen_d != 32'd0) ? PH_KEY : PH_VLEN;
        end
      end
      PH_KEY: begin
        crc_d     = crc_upd;
        emit_data = 1'b1;
        data_kind = KIND_KEY;
        fcnt_d    = fcnt_inc;
        if (fcnt_inc >= klen_q) begin
          fcnt_d  = 32'd0;
          phase_d = PH_VLEN;
        end
      end
      PH_VLEN: begin
        crc_d  = crc_upd;
        vlen_d = {vlen_q[23:0], in_byte_i};
        fcnt_d = fcnt_inc;
        if (fcnt_inc >= LEN_BYTES) begin
          fcnt_d  = 32'd0;
          phase_d = (vlen_d != 32'd0) ? PH_VAL : PH_CRC;
        end
      end
      PH_VAL: begin
        crc_d     = crc_upd;
        emit_data = 1'b1;
        data_kind = KIND_VALUE;
        fcnt_d    = fcnt_inc;
        if (fcnt_inc >= vlen_q) begin
          fcnt_d  = 32'd0;
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        stored_d = {stored_q[23:0], in_byte_i};
        fcnt_d   = fcnt_inc;
        done     = (fcnt_inc >= LEN_BYTES);
      end
      default: begin
        // Sequence number field; an unknown phase code is handled the same way.
        crc_d  = crc_upd;
        seq_d  = {seq_q[55:0], in_byte_i};
        fcnt_d = fcnt_inc;
        if (fcnt_inc >= SEQ_BYTES) begin
          fcnt_d  = 32'd0;
          phase_d = PH_OP;
        end else begin
          phase_d = PH_SEQ;
        end
      end
    endcase

    // Status code of a finished or cut-off record.
    if (done) begin
      st = ((crc_q ^ CRC_INIT) == stored_d) ? ST_OK : ST_CRC_ERROR;
    end else if (bytes_seen_d < FIXED_BYTES) begin
      st = ST_SHORT_HDR;
    end else if (!(phase_d == PH_VAL || phase_d == PH_CRC)) begin
      st = ST_SHORT_KEY;
    end else begin
      st = ST_SHORT_REC;
    end

    res_o.data_vld           = in_vld_i & emit_data;
    res_o.stat_vld           = in_vld_i & (done | in_eob_i);
    res_o.data_res           = '0;
    res_o.data_res.kind      = data_kind;
    res_o.data_res.data_byte = in_byte_i;
    res_o.data_res.last      = ~(done | in_eob_i);
    res_o.stat_res           = '0;
    res_o.stat_res.kind      = KIND_STATUS;
    res_o.stat_res.seq_num   = seq_d;
    res_o.stat_res.op_code   = op_d;
    res_o.stat_res.key_len   = klen_d;
    res_o.stat_res.val_len   = vlen_d;
    res_o.stat_res.status    = st;
    res_o.stat_res.last      = 1'b1;

    // Any status closes the record and restarts the parser.
    if (done || in_eob_i) begin
      phase_d      = PH_SEQ;
      fcnt_d       = 32'd0;
      bytes_seen_d = 5'd0;
      seq_d        = 64'd0;
      op_d         = 8'd0;
      klen_d       = 32'd0;
      vlen_d       = 32'd0;
      crc_d        = CRC_INIT;
      stored_d     = 32'd0;
    end
  end

  // Parser state, updated once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEQ;
      fcnt_q       <= 32'd0;
      bytes_seen_q <= 5'd0;
      seq_q        <= 64'd0;
      op_q         <= 8'd0;
      klen_q       <= 32'd0;
      vlen_q       <= 32'd0;
      crc_q        <= CRC_INIT;
      stored_q     <= 32'd0;
    end else if (in_vld_i) begin
      phase_q      <= phase_d;
      fcnt_q       <= fcnt_d;
      bytes_seen_q <= bytes_seen_d;
      seq_q        <= seq_d;
      op_q         <= op_d;
      klen_q       <= klen_d;
      vlen_q       <= vlen_d;
      crc_q        <= crc_d;
      stored_q     <= stored_d;
    end
  end

  `LRP_ASSERT(a_bytes_seen_sat, bytes_seen_q <= FIXED_BYTES, "byte count passed its limit")
  `LRP_ASSERT(a_restart_after_status, res_o.stat_vld |=> (phase_q == PH_SEQ) && (crc_q == CRC_INIT), "parser did not restart after status")
  `LRP_ASSERT(a_data_phase, res_o.data_vld |-> (phase_q == PH_KEY || phase_q == PH_VAL), "data beat outside key or value field")

endmodule

// ===== rtl/log_record_parser_crc_check_top.sv =====
`timescale 1ns / 1ps
`include "log_record_parser_crc_check_top_defines.svh"
// Channel  | Dir | Fields
// s_axis   | in  | tdata: in_byte[7:0]; tlast: end_of_buffer
// m_axis   | out | tuser: out_kind; tdata: data_byte, sequence_number, op_code,
//          |     |   key_length, value_length, status; tlast: last
//
// One input byte is accepted per cycle while input ready is high; its results
// are written into a result queue at the accepting edge, so the first result is
// visible in the next cycle. A byte that yields both a key/value beat and a
// status beat adds two queue entries; the queue depth sets how much is absorbed.
// Input ready drops while fewer than two queue entries are free.
// Reset is asynchronous, active low, and clears the parser and the queue.

module log_record_parser_crc_check_top #(
  parameter int unsigned FifoDepth = lrp_crc_pkg::LRP_FIFO_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] in_byte
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] data_byte, [71:8] sequence_number, [79:72] op_code,
  // [111:80] key_length, [143:112] value_length, [146:144] status, rest zero
  output logic [lrp_crc_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  output logic [1:0]                        m_axis_tuser_o,  // [1:0] out_kind
  output logic                              m_axis_tlast_o
);
  import lrp_crc_pkg::*;

  localparam int unsigned AW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CW = $clog2(FifoDepth + 1);

  parse_res_t      par;
  logic            in_acc;
  logic            out_acc;
  result_t         fifo_q [FifoDepth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      push_n;
  result_t         first_res;
  result_t         head;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(FifoDepth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign s_axis_tready_o = (cnt_q <= CW'(FifoDepth - 2));
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o & m_axis_tready_i;

  lrp_crc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_acc),
    .in_byte_i (s_axis_tdata_i),
    .in_eob_i  (s_axis_tlast_i),
    .res_o     (par)
  );

  // Queue write side: up to two results per accepted beat.
  always_comb begin
    push_n     = {1'b0, par.data_vld} + {1'b0, par.stat_vld};
    first_res  = par.data_vld ? par.data_res : par.stat_res;
    wr_ptr_nxt = ptr_inc(wr_ptr_q);
    case (push_n)
      2'd1:    wr_ptr_d = wr_ptr_nxt;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nxt);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = out_acc ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_n) - CW'(out_acc);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_nxt] <= par.stat_res;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Output beat from the queue head.
  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tdata_o  = {5'd0, head.status, head.val_len, head.key_len,
                            head.op_code, head.seq_num, head.data_byte};

  `LRP_ASSERT(a_cnt_bound, cnt_q <= CW'(FifoDepth), "result queue overflow")
  `LRP_ASSERT(a_status_last, out_acc && (m_axis_tuser_o == KIND_STATUS) |-> m_axis_tlast_o, "status beat without last")
  `LRP_ASSERT(a_kind_legal, m_axis_tvalid_o |-> (m_axis_tuser_o == KIND_KEY || m_axis_tuser_o == KIND_VALUE || m_axis_tuser_o == KIND_STATUS), "illegal result kind")
  `LRP_ASSERT(a_no_push_when_full, (push_n != 2'd0) |-> (cnt_q <= CW'(FifoDepth - 2)), "result pushed without queue space")

endmodule

// ===== sim/lrp_record_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the log record parser, predicts the result
// beats of every accepted input byte, and compares them in order.
module lrp_record_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      in_byte_i,
  input  logic                            in_eob_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [lrp_crc_pkg::TDATA_W-1:0] out_data_i,
  input  logic [1:0]                      out_kind_i,
  input  logic                            out_last_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_o
);
  import lrp_crc_pkg::*;

  // Parser state as the record is shifted in.
  phase_e      parse_phase;
  logic [31:0] field_cnt;
  logic [4:0]  rec_bytes;
  logic [63:0] seq_acc;
  logic [7:0]  op_acc;
  logic [31:0] klen_acc;
  logic [31:0] vlen_acc;
  logic [31:0] crc_acc;
  logic [31:0] crc_field;

  // Result beats still owed by the parser, oldest first.
  result_t     owed_results[$];
  int unsigned beat_idx;

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    error_count_o++;
  endtask

  task automatic clear_record();
    parse_phase = PH_SEQ;
    field_cnt   = '0;
    rec_bytes   = '0;
    seq_acc     = '0;
    op_acc      = '0;
    klen_acc    = '0;
    vlen_acc    = '0;
    crc_acc     = CRC_INIT;
    crc_field   = '0;
  endtask

  // Advances the record state by one byte and queues the beats it causes.
  task automatic predict_byte(input logic [7:0] b, input logic eob);
    result_t    beat;
    bit         rec_done;
    bit         has_payload;
    logic [2:0] rec_status;
    beat        = '0;
    rec_done    = 1'b0;
    has_payload = 1'b0;
    if (rec_bytes < FIXED_BYTES) begin
      rec_bytes++;
    end
    // Everything up to the CRC field is covered by the CRC.
    if (parse_phase != PH_CRC) begin
      crc_acc = crc32_update(crc_acc, b);
    end
    case (parse_phase)
      PH_OP: begin
        op_acc      = b;
        parse_phase = PH_KLEN;
        field_cnt   = '0;
      end
      PH_KLEN: begin
        klen_acc = {klen_acc[23:0], b};
        field_cnt++;
        if (field_cnt >= LEN_BYTES) begin
          field_cnt   = '0;
          parse_phase = (klen_acc != '0) ? PH_KEY : PH_VLEN;
        end
      end
      PH_KEY: begin
        has_payload    = 1'b1;
        beat.kind      = KIND_KEY;
        beat.data_byte = b;
        field_cnt++;
        if (field_cnt >= klen_acc) begin
          field_cnt   = '0;
          parse_phase = PH_VLEN;
        end
      end
      PH_VLEN: begin
        vlen_acc = {vlen_acc[23:0], b};
        field_cnt++;
        if (field_cnt >= LEN_BYTES) begin
          field_cnt   = '0;
          parse_phase = (vlen_acc != '0) ? PH_VAL : PH_CRC;
        end
      end
      PH_VAL: begin
        has_payload    = 1'b1;
        beat.kind      = KIND_VALUE;
        beat.data_byte = b;
        field_cnt++;
        if (field_cnt >= vlen_acc) begin
          field_cnt   = '0;
          parse_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_field = {crc_field[23:0], b};
        field_cnt++;
        rec_done = (field_cnt >= LEN_BYTES);
      end
      default: begin
        // The sequence field; any other phase code is treated the same way.
        seq_acc = {seq_acc[55:0], b};
        field_cnt++;
        if (field_cnt >= SEQ_BYTES) begin
          field_cnt   = '0;
          parse_phase = PH_OP;
        end else begin
          parse_phase = PH_SEQ;
        end
      end
    endcase

    if (has_payload) begin
      beat.last    = !(rec_done || eob);
      owed_results = {owed_results, beat};
    end

    // A status beat closes the record, complete or cut short.
    if (rec_done || eob) begin
      if (rec_done) begin
        rec_status = ((crc_acc ^ CRC_INIT) == crc_field) ? ST_OK : ST_CRC_ERROR;
      end else if (rec_bytes < FIXED_BYTES) begin
        rec_status = ST_SHORT_HDR;
      end else if (parse_phase == PH_VAL || parse_phase == PH_CRC) begin
        rec_status = ST_SHORT_REC;
      end else begin
        rec_status = ST_SHORT_KEY;
      end
      beat           = '0;
      beat.kind      = KIND_STATUS;
      beat.seq_num   = seq_acc;
      beat.op_code   = op_acc;
      beat.key_len   = klen_acc;
      beat.val_len   = vlen_acc;
      beat.status    = rec_status;
      beat.last      = 1'b1;
      owed_results   = {owed_results, beat};
      clear_record();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result beat %0d, %s: got %0h, expected %0h",
                                beat_idx, name, got, want));
    end
  endtask

  // Compares one output beat with the oldest owed result.
  task automatic compare_result();
    result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result beat %0d arrived with nothing owed", beat_idx));
    end else begin
      want = owed_results.pop_front();
      check_field("out_kind", out_kind_i, want.kind);
      check_field("data_byte", out_data_i[7:0], want.data_byte);
      check_field("sequence_number", out_data_i[71:8], want.seq_num);
      check_field("op_code", out_data_i[79:72], want.op_code);
      check_field("key_length", out_data_i[111:80], want.key_len);
      check_field("value_length", out_data_i[143:112], want.val_len);
      check_field("status", out_data_i[146:144], want.status);
      check_field("tdata padding", out_data_i[TDATA_W-1:147], '0);
      check_field("last", out_last_i, want.last);
    end
    beat_idx++;
  endtask

  // Results are registered in the result queue before they appear, so compare first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_record();
      owed_results.delete();
      beat_idx      = 0;
      error_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_result();
      end
      if (in_valid_i && in_ready_i) begin
        predict_byte(in_byte_i, in_eob_i);
      end
    end
    pending_o = owed_results.size();
  end

endmodule

// ===== sim/log_record_parser_crc_check_top_tb.sv =====
`timescale 1ns / 1ps

module log_record_parser_crc_check_top_tb;
  import lrp_crc_pkg::*;

  // Receiver stall styles.
  localparam int unsigned RX_OPEN   = 0;
  localparam int unsigned RX_COIN   = 1;
  localparam int unsigned RX_SKIP4  = 2;
  localparam int unsigned RX_SPARSE = 3;
  localparam int unsigned RX_HOLD   = 4;

  localparam int unsigned RANDOM_BYTES = 700;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte   = '0;
  logic               in_eob    = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [TDATA_W-1:0] out_data;
  logic [1:0]         out_kind;
  logic               out_last;
  int unsigned        mismatch_count;
  int unsigned        pending_beats;

  int unsigned        burst_left = 0;
  int unsigned        bytes_sent = 0;

  log_record_parser_crc_check_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),
    .s_axis_tlast_i  (in_eob),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_kind),
    .m_axis_tlast_o  (out_last)
  );

  lrp_record_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_byte_i     (in_byte),
    .in_eob_i      (in_eob),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .out_kind_i    (out_kind),
    .out_last_i    (out_last),
    .error_count_o (mismatch_count),
    .pending_o     (pending_beats)
  );

  always #10 clk = ~clk;

  // Offers one byte and waits until it is accepted; bursts are broken by short gaps.
  task automatic send_beat(input logic [7:0] b, input logic eob);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eob   <= eob;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sends one record byte unless the record was already cut short.
  task automatic record_byte(input logic [7:0] b, input int cut, input bit eob_here,
                             inout logic [31:0] crc, inout int pos, inout bit stopped);
    if (!stopped) begin
      crc = crc_byte(crc, b);
      send_beat(b, (pos == cut) || eob_here);
      stopped = (pos == cut);
      pos++;
    end
  endtask

  // Sends a record with random key and value bytes. A cut position of -1
  // sends the whole record; otherwise the buffer ends at that byte.
  task automatic send_record(input logic [63:0] seq, input logic [7:0] op,
                             input logic [31:0] klen, input logic [31:0] vlen,
                             input bit bad_crc, input int cut, input bit eob_at_end);
    logic [31:0] crc;
    logic [31:0] crc_word;
    int          pos;
    bit          stopped;
    crc     = CRC_INIT;
    pos     = 0;
    stopped = 1'b0;
    for (int i = 0; i < 8; i++) begin
      record_byte(seq[63 - 8 * i -: 8], cut, 1'b0, crc, pos, stopped);
    end
    record_byte(op, cut, 1'b0, crc, pos, stopped);
    for (int i = 0; i < 4; i++) begin
      record_byte(klen[31 - 8 * i -: 8], cut, 1'b0, crc, pos, stopped);
    end
    for (longint unsigned i = 0; i < klen && !stopped; i++) begin
      record_byte(8'($urandom), cut, 1'b0, crc, pos, stopped);
    end
    for (int i = 0; i < 4; i++) begin
      record_byte(vlen[31 - 8 * i -: 8], cut, 1'b0, crc, pos, stopped);
    end
    for (longint unsigned i = 0; i < vlen && !stopped; i++) begin
      record_byte(8'($urandom), cut, 1'b0, crc, pos, stopped);
    end
    crc_word = ~crc;
    if (bad_crc) begin
      crc_word ^= 32'd1 << $urandom_range(0, 31);
    end
    for (int i = 0; i < 4; i++) begin
      record_byte(crc_word[31 - 8 * i -: 8], cut, eob_at_end && (i == 3), crc, pos, stopped);
    end
  endtask

  // Mostly short lengths, some longer ones, and full-range values for cut records.
  function automatic logic [31:0] pick_length(input bit allow_huge);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      return $urandom_range(0, 6);
    end
    if (r < 18 || !allow_huge) begin
      return $urandom_range(7, 40);
    end
    return $urandom;
  endfunction

  // Receiver: segments of different stall styles, with a long hold-off now
  // and then so that the result queue fills and the input stalls.
  initial begin : rx_stall_pattern
    int unsigned seg;
    int unsigned span;
    int unsigned style;
    seg = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (seg == 3 || $urandom_range(0, 15) == 0) begin
        style = RX_HOLD;
        span  = $urandom_range(40, 90);
      end else begin
        style = $urandom_range(RX_OPEN, RX_SPARSE);
        span  = $urandom_range(8, 60);
      end
      for (int k = 0; k < span; k++) begin
        case (style)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SKIP4:  out_ready <= (k % 4) != 3;
          RX_SPARSE: out_ready <= (k % 5) == 0;
          default:   out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
      seg++;
    end
  end

  initial begin : byte_stream
    int unsigned      random_goal;
    int unsigned      pick;
    int unsigned      noise_len;
    bit               cut_rec;
    logic [31:0]      klen;
    logic [31:0]      vlen;
    longint unsigned  total;
    int               cut;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records.
    send_record(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'd0, 32'd0, 1'b0, -1, 1'b1);
    send_record(64'd0, 8'h00, 32'd1, 32'd2, 1'b0, -1, 1'b0);
    send_record(64'h0123_4567_89AB_CDEF, 8'h5A, 32'd3, 32'd1, 1'b1, -1, 1'b0);
    // Buffer ends on the first byte, and inside the CRC of a minimal record.
    send_record(64'h8000_0000_0000_0001, 8'h01, 32'd0, 32'd0, 1'b0, 0, 1'b0);
    send_record(64'h7FFF_FFFF_FFFF_FFFE, 8'h80, 32'd0, 32'd0, 1'b0, 19, 1'b0);
    // Ends on a key byte early in the record: key beat, then a short key status.
    send_record(64'h5555_AAAA_5555_AAAA, 8'h33, 32'd12, 32'd0, 1'b0, 20, 1'b0);
    // Ends inside a huge key, and inside the value length after a long key.
    send_record(64'hAAAA_5555_AAAA_5555, 8'hCC, 32'hFFFF_FFFF, 32'd0, 1'b0, 22, 1'b0);
    send_record(64'h0F0F_0F0F_F0F0_F0F0, 8'h0F, 32'd10, 32'd3, 1'b0, 24, 1'b0);
    // Ends inside a huge value, and inside the CRC after a key.
    send_record(64'hF0F0_F0F0_0F0F_0F0F, 8'hF0, 32'd0, 32'hFFFF_FFFF, 1'b0, 25, 1'b0);
    send_record(64'h1122_3344_5566_7788, 8'h99, 32'd2, 32'd0, 1'b0, 21, 1'b0);

    // Random part: mostly well-formed records, some cut short, some noise.
    random_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        cut_rec = (pick >= 70);
        klen    = pick_length(cut_rec);
        vlen    = pick_length(cut_rec);
        total   = 64'd21 + klen + vlen;
        cut     = cut_rec ? $urandom_range(0, (total > 60) ? 59 : int'(total) - 1) : -1;
        send_record({$urandom, $urandom}, 8'($urandom), klen, vlen,
                    $urandom_range(0, 6) == 0, cut, $urandom_range(0, 2) == 0);
      end else begin
        // Noise always ends with end of buffer so the next record starts clean.
        noise_len = $urandom_range(1, 12);
        for (int i = 0; i < noise_len; i++) begin
          send_beat(8'($urandom), (i == noise_len - 1) || ($urandom_range(0, 5) == 0));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the owed results, then keep watching for stray beats before finishing.
    do @(posedge clk); while (pending_beats != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== log_record_parser_crc_check_top.f =====
+incdir+rtl
rtl/lrp_crc_pkg.sv
rtl/lrp_crc_parser.sv
rtl/log_record_parser_crc_check_top.sv
sim/lrp_record_checker.sv
sim/log_record_parser_crc_check_top_tb.sv
